>>> hdl/cdtt_pkg.sv
// Shared constants, codes and types of the countdown timer table.
// Used by the channel interfaces, the cell row, the controller and the checker.
package cdtt_pkg;

   localparam int SLOTS = 16;
   localparam int ID_W  = 16;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_KILL = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_CLEARED   = 3'd3,
      ST_EXPIRED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_LOAD   = 3'd1,
      ACT_RELOAD = 3'd2,
      ACT_DEC    = 3'd3,
      ACT_SHIFT  = 3'd4
   } act_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] remaining;
   } entry_type;

   typedef struct packed {
      act_type          act;
      logic [CNT_W-1:0] pos;
      logic [ID_W-1:0]  id;
      logic [ID_W-1:0]  value;
   } cell_cmd_type;

endpackage

>>> hdl/cdtt_req_if.sv
// Request channel of the countdown timer table: valid, ready and the command.
// Depends on cdtt_pkg for the identifier width.
interface cdtt_req_if import cdtt_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      op;
   logic [ID_W-1:0] timer_id;
   logic [ID_W-1:0] elapse;

   modport source (output valid, output op, output timer_id, output elapse, input ready);
   modport sink (input valid, input op, input timer_id, input elapse, output ready);
endinterface

>>> hdl/cdtt_rsp_if.sv
// Response channel of the countdown timer table: valid, ready and one result.
// Depends on cdtt_pkg for the identifier width.
interface cdtt_rsp_if import cdtt_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [2:0]      status;
   logic [ID_W-1:0] expired_id;
   logic            last;

   modport source (output valid, output status, output expired_id, output last, input ready);
   modport sink (input valid, input status, input expired_id, input last, output ready);
endinterface

>>> hdl/countdown_timer_table_unit.sv
// Countdown timer table: an ordered list of up to SLOTS timers kept in a row of
// cells, oldest first. Once a request transaction is taken, the controller
// moves one position along the cell row per cycle. A set or a kill visits
// the live entries from the oldest until it finds the identifier or the end
// of the list; a kill of identifier zero clears the list without a walk. A
// tick visits every live entry from the newest and gives one response per
// expired entry, or a single OK response when none expires. A held-off
// response stalls the walk, and a new request is taken as soon as the previous
// one has placed its last response in the output register. No clearing pass
// is needed after reset.
// Depends on cdtt_pkg, the channel interfaces, cdtt_cell and cdtt_ctrl.
module countdown_timer_table_unit import cdtt_pkg::*; (
   input logic        clock,
   input logic        reset,
   cdtt_req_if.sink   req_ch,
   cdtt_rsp_if.source rsp_ch
);

   entry_type    slot_q  [SLOTS];
   entry_type    upper_q [SLOTS];
   cell_cmd_type cell_cmd;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      if (g == SLOTS - 1) begin : g_top
         assign upper_q[g] = '0;
      end else begin : g_mid
         assign upper_q[g] = slot_q[g+1];
      end

      cdtt_cell u_cell (
         .clock      (clock),
         .cell_index (CNT_W'(g)),
         .cmd        (cell_cmd),
         .upper      (upper_q[g]),
         .entry      (slot_q[g])
      );
   end

   cdtt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .slot_q   (slot_q),
      .cell_cmd (cell_cmd)
   );

endmodule

>>> hdl/cdtt_cell.sv
// One list entry of the timer table: identifier and remaining tick count.
// Acts on the broadcast cell command and takes its upper neighbor's entry on a shift.
// Depends on cdtt_pkg.
module cdtt_cell import cdtt_pkg::*; (
   input  logic             clock,
   input  logic [CNT_W-1:0] cell_index,
   input  cell_cmd_type     cmd,
   input  entry_type        upper,
   output entry_type        entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      hit;
   logic      at_or_above;

   always_comb begin
      hit         = (cell_index == cmd.pos);
      at_or_above = (cell_index >= cmd.pos);
      entry_in    = entry_ff;
      case (cmd.act)
         ACT_LOAD: begin
            if (hit) begin
               entry_in.id        = cmd.id;
               entry_in.remaining = cmd.value;
            end
         end
         ACT_RELOAD: begin
            if (hit) begin
               entry_in.remaining = cmd.value;
            end
         end
         ACT_DEC: begin
            if (hit) begin
               entry_in.remaining = entry_ff.remaining - ID_W'(1);
            end
         end
         ACT_SHIFT: begin
            if (at_or_above) begin
               entry_in = upper;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> hdl/cdtt_ctrl.sv
// Controller of the timer table: takes a request transaction, walks a position
// along the cell row one entry per cycle unless a held-off response stalls it,
// and drives the response register. Depends on cdtt_pkg and the two channel interfaces.
module cdtt_ctrl import cdtt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cdtt_req_if.sink     req_ch,
   cdtt_rsp_if.source   rsp_ch,
   input  entry_type    slot_q [SLOTS],
   output cell_cmd_type cell_cmd
);

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [ID_W-1:0]  key_ff, key_in;
   logic [ID_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_ff, pend_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic [CNT_W-1:0] idx;
   entry_type        view;
   logic             match;
   logic             expiring;
   logic             emit;
   status_type       emit_status;
   logic [ID_W-1:0]  emit_id;
   logic             emit_last;
   logic             finish;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ch.ready;
      idx      = (op_ff == OP_TICK) ? (pos_ff - CNT_W'(1)) : pos_ff;
      view     = slot_q[idx[IDX_W-1:0]];
      match    = (view.id == key_ff);
      expiring = (view.remaining <= ID_W'(1));

      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;

      cell_cmd.act   = ACT_NONE;
      cell_cmd.pos   = idx;
      cell_cmd.id    = key_ff;
      cell_cmd.value = value_ff;

      emit        = 1'b0;
      emit_status = ST_OK;
      emit_id     = '0;
      emit_last   = 1'b1;
      finish      = 1'b0;

      req_ch.ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = op_type'(req_ch.op);
               key_in   = req_ch.timer_id;
               value_in = req_ch.elapse;
               pend_in  = 1'b0;
               pos_in   = (op_type'(req_ch.op) == OP_TICK) ? count_ff : '0;
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            case (op_ff)
               OP_SET: begin
                  if (pos_ff == count_ff) begin
                     if (out_free) begin
                        emit    = 1'b1;
                        finish  = 1'b1;
                        emit_id = key_ff;
                        if (count_ff == CNT_W'(SLOTS)) begin
                           emit_status = ST_FULL;
                        end else begin
                           cell_cmd.act = ACT_LOAD;
                           count_in     = count_ff + CNT_W'(1);
                        end
                     end
                  end else if (match) begin
                     if (out_free) begin
                        cell_cmd.act = ACT_RELOAD;
                        emit         = 1'b1;
                        finish       = 1'b1;
                        emit_id      = key_ff;
                     end
                  end else begin
                     pos_in = pos_ff + CNT_W'(1);
                  end
               end
               OP_KILL: begin
                  if (key_ff == '0) begin
                     if (out_free) begin
                        count_in    = '0;
                        emit        = 1'b1;
                        finish      = 1'b1;
                        emit_status = ST_CLEARED;
                     end
                  end else if (pos_ff == count_ff) begin
                     if (out_free) begin
                        emit        = 1'b1;
                        finish      = 1'b1;
                        emit_status = ST_NOT_FOUND;
                        emit_id     = key_ff;
                     end
                  end else if (match) begin
                     if (out_free) begin
                        cell_cmd.act = ACT_SHIFT;
                        count_in     = count_ff - CNT_W'(1);
                        emit         = 1'b1;
                        finish       = 1'b1;
                        emit_id      = key_ff;
                     end
                  end else begin
                     pos_in = pos_ff + CNT_W'(1);
                  end
               end
               OP_TICK: begin
                  // An expired entry is held back one step so that the final one
                  // can carry the last flag.
                  if (pos_ff == '0) begin
                     if (out_free) begin
                        emit   = 1'b1;
                        finish = 1'b1;
                        if (pend_ff) begin
                           emit_status = ST_EXPIRED;
                           emit_id     = pend_id_ff;
                        end
                     end
                  end else if (expiring) begin
                     if (!pend_ff || out_free) begin
                        cell_cmd.act = ACT_SHIFT;
                        count_in     = count_ff - CNT_W'(1);
                        pos_in       = pos_ff - CNT_W'(1);
                        pend_in      = 1'b1;
                        pend_id_in   = view.id;
                        if (pend_ff) begin
                           emit        = 1'b1;
                           emit_status = ST_EXPIRED;
                           emit_id     = pend_id_ff;
                           emit_last   = 1'b0;
                        end
                     end
                  end else begin
                     cell_cmd.act = ACT_DEC;
                     pos_in       = pos_ff - CNT_W'(1);
                  end
               end
               default: begin
                  if (out_free) begin
                     emit   = 1'b1;
                     finish = 1'b1;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_id_in     = emit_id;
         rsp_last_in   = emit_last;
      end
      if (finish) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.expired_id = rsp_id_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

>>> hdl/cdtt_checker.sv
// Port-level checks of the countdown timer table, bound to the top level.
// Depends on cdtt_pkg and countdown_timer_table_unit.
module cdtt_checker import cdtt_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [2:0]      rsp_status,
   input logic [ID_W-1:0] rsp_expired_id,
   input logic            rsp_last
);

   // The output register is empty right after reset.
   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only expiry reports may leave a transaction open.
   a_open_only_expired : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ST_EXPIRED))
      else $error("non-final response without expired status");

   // A taken request leaves the block busy in the cycle after it.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after a transaction");

   // A stalled response holds its contents.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_expired_id) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind countdown_timer_table_unit cdtt_checker u_cdtt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_expired_id (rsp_ch.expired_id),
   .rsp_last       (rsp_ch.last)
);

>>> tb/sv/testbench.sv
// Self-checking testbench of countdown_timer_table_unit: directed and random timer commands.
// Expected responses come from a behavioral timer list kept in step with the accepted requests.
// Depends on cdtt_pkg, cdtt_req_if, cdtt_rsp_if and the countdown_timer_table_unit RTL.
module testbench import cdtt_pkg::*; ();

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct {
      status_type      status;
      logic [ID_W-1:0] id;
      logic            last;
   } timer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cdtt_req_if req_ch ();
   cdtt_rsp_if rsp_ch ();

   countdown_timer_table_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [ID_W-1:0] timer_ids [SLOTS];
   logic [ID_W-1:0] timer_left [SLOTS];
   int              timer_count = 0;

   timer_result_type expected_results [$];
   timer_result_type oldest_result;
   int              error_count = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 7;
   int              recv_idle_pct = 84;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, expected_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: random back-pressure and comparison against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response: status %0d id %h last %b", $time,
                        rsp_ch.status, rsp_ch.expired_id, rsp_ch.last);
               error_count++;
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_ch.status !== oldest_result.status ||
                   rsp_ch.expired_id !== oldest_result.id ||
                   rsp_ch.last !== oldest_result.last) begin
                  $display("%0t: expected status %0d id %h last %b, got status %0d id %h last %b",
                           $time, oldest_result.status, oldest_result.id, oldest_result.last,
                           rsp_ch.status, rsp_ch.expired_id, rsp_ch.last);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void push_result(input status_type status, input logic [ID_W-1:0] id,
                                       input logic last);
      timer_result_type r;
      r.status = status;
      r.id     = id;
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   function automatic void drop_timer(input int pos);
      int k;
      for (k = pos; k + 1 < timer_count; k++) begin
         timer_ids[k]  = timer_ids[k + 1];
         timer_left[k] = timer_left[k + 1];
      end
      timer_count--;
   endfunction

   function automatic int find_timer(input logic [ID_W-1:0] id);
      int k;
      for (k = 0; k < timer_count; k++)
         if (timer_ids[k] == id)
            return k;
      return -1;
   endfunction

   function automatic void update_timer_list(input op_type op, input logic [ID_W-1:0] id,
                                             input logic [ID_W-1:0] elapse);
      int pos;
      int expired;
      int k;
      case (op)
         OP_SET: begin
            pos = find_timer(id);
            if (pos >= 0) begin
               timer_left[pos] = elapse;
               push_result(ST_OK, id, 1'b1);
            end else if (timer_count >= SLOTS) begin
               push_result(ST_FULL, id, 1'b1);
            end else begin
               timer_ids[timer_count]  = id;
               timer_left[timer_count] = elapse;
               timer_count++;
               push_result(ST_OK, id, 1'b1);
            end
         end
         OP_KILL: begin
            if (id == '0) begin
               timer_count = 0;
               push_result(ST_CLEARED, '0, 1'b1);
            end else begin
               pos = find_timer(id);
               if (pos >= 0) begin
                  drop_timer(pos);
                  push_result(ST_OK, id, 1'b1);
               end else begin
                  push_result(ST_NOT_FOUND, id, 1'b1);
               end
            end
         end
         OP_TICK: begin
            expired = 0;
            for (k = timer_count - 1; k >= 0; k--) begin
               if (timer_left[k] <= 1) begin
                  push_result(ST_EXPIRED, timer_ids[k], 1'b0);
                  drop_timer(k);
                  expired++;
               end else begin
                  timer_left[k] = timer_left[k] - 1'b1;
               end
            end
            if (expired == 0)
               push_result(ST_OK, '0, 1'b1);
            else
               expected_results[$].last = 1'b1;
         end
         default: begin
            push_result(ST_OK, '0, 1'b1);
         end
      endcase
   endfunction

   task automatic send_command(input op_type op, input logic [ID_W-1:0] id,
                               input logic [ID_W-1:0] elapse);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.timer_id <= id;
      req_ch.elapse   <= elapse;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      update_timer_list(op, id, elapse);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_results.size() != 0);
   endtask

   function automatic logic [ID_W-1:0] random_timer_id();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80)
         return ID_W'($urandom_range(1, 24));
      else if (pick < 85)
         return '0;
      else
         return ID_W'($urandom);
   endfunction

   function automatic logic [ID_W-1:0] random_elapse();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         return ID_W'($urandom_range(0, 6));
      else if (pick < 90)
         return ID_W'($urandom_range(7, 40));
      else
         return ID_W'($urandom);
   endfunction

   task automatic test_empty_table();
      send_command(OP_TICK, 16'h0000, 16'h0000);
      send_command(OP_KILL, 16'hFFFF, 16'h0000);
      send_command(OP_NONE, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_set_and_reload();
      send_command(OP_SET, 16'h0000, 16'h0001);
      send_command(OP_SET, 16'hFFFF, 16'hFFFF);
      send_command(OP_SET, 16'h0001, 16'h0000);
      send_command(OP_SET, 16'h0000, 16'h0002);
   endtask

   task automatic test_tick_expiry();
      send_command(OP_TICK, 16'hFFFF, 16'hFFFF);
      send_command(OP_SET, 16'h8000, 16'h0001);
      send_command(OP_TICK, 16'h0000, 16'h0000);
   endtask

   task automatic test_kill_by_id();
      send_command(OP_KILL, 16'hFFFF, 16'hFFFF);
      send_command(OP_KILL, 16'hFFFF, 16'h0000);
   endtask

   task automatic test_full_table();
      int k;
      for (k = 0; k < SLOTS; k++)
         send_command(OP_SET, ID_W'(16'h0100 + k), ID_W'(16'hFFFF - k));
      send_command(OP_SET, 16'h0200, 16'h0005);
      send_command(OP_SET, 16'h0105, 16'h0003);
      send_command(OP_KILL, 16'h0000, 16'h0000);
   endtask

   task automatic test_random_traffic(input int count);
      int n;
      int pick;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] elapse;
      for (n = 0; n < count; n++) begin
         pick   = $urandom_range(99);
         id     = random_timer_id();
         elapse = random_elapse();
         if (pick < 45)
            send_command(OP_SET, id, elapse);
         else if (pick < 57)
            send_command(OP_KILL, ($urandom_range(9) == 0) ? '0 : id, elapse);
         else if (pick < 97)
            send_command(OP_TICK, id, elapse);
         else
            send_command(OP_NONE, id, elapse);
      end
   endtask

   initial begin
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_NONE;
      req_ch.timer_id <= '0;
      req_ch.elapse   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_set_and_reload();
      test_tick_expiry();
      test_kill_by_id();
      test_full_table();
      test_random_traffic(130);
      wait_for_drain();

      send_idle_pct = 84;
      recv_idle_pct = 7;
      test_random_traffic(130);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(130);
      wait_for_drain();

      repeat (4 * SLOTS) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
